// File: rtl/sl1c_pkg.sv
// Shared types, constants and helpers for the split L1 / victim L2 tag model.
`timescale 1ns / 1ps
package sl1c_pkg;

  localparam int unsigned L1_LINES_MAX_DEF = 1024;
  localparam int unsigned L2_BYTES_DEF     = 16384;
  localparam int unsigned L2_WAYS_DEF      = 8;
  localparam int unsigned L1_WAYS_MAX_DEF  = 8;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_FETCH = 2'd2;
  localparam logic [1:0] ACT_RSVD  = 2'd3;
  localparam logic [1:0] KIND_DIRTY = 2'd1;

  localparam logic [1:0] CFG_L1_BYTES  = 2'd0;
  localparam logic [1:0] CFG_BLK_BYTES = 2'd1;
  localparam logic [1:0] CFG_L1_WAYS   = 2'd2;

  // One stored line: valid, tag, stamp and kind.
  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] stamp;
    logic [1:0]  kind;
  } line_t;

  localparam int unsigned LINE_W = 67;

  // Result word flags.
  typedef struct packed {
    logic dirty_evict;
    logic victim_to_l2;
    logic l2_hit;
    logic l2_probed;
    logic l1_hit;
  } result_t;

  function automatic int unsigned clog2_floor(input int unsigned v);
    int unsigned k;
    k = 0;
    for (int i = 1; i < 32; i++) begin
      if ((v >> i) != 0) k = i;
    end
    return k;
  endfunction

endpackage

// File: rtl/sl1c_ram.sv
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module sl1c_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/split_l1_exclusive_l2_cache_model_top.sv
// Top level of the split L1 / exclusive victim L2 tag model.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata[31:0] address, tuser[1:0] action
//  m_axis    out  m_axis_tvalid/tready      tdata[4:0] l1_hit..dirty_evict
//  cfg       in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// One word at a time is handled by a sequencer that walks the memories one
// line at a time, a read state and a check state per line: L1 set scan, LRU
// replacement, L2 probe scan and L2 insert scan with LRU replacement.
// The time taken per word is set by the number of lines scanned.
// After reset a clearing pass writes every L1 and L2 line invalid, during
// which no word is accepted.
// A finished result sits in the output register; the next word is taken once
// that register is empty or drained in the same cycle. Configuration writes
// are accepted only while the sequencer is idle.
module split_l1_exclusive_l2_cache_model_top #(
  parameter int unsigned L1_LINES_MAX = sl1c_pkg::L1_LINES_MAX_DEF,
  parameter int unsigned L2_BYTES     = sl1c_pkg::L2_BYTES_DEF,
  parameter int unsigned L2_WAYS      = sl1c_pkg::L2_WAYS_DEF,
  parameter int unsigned L1_WAYS_MAX  = sl1c_pkg::L1_WAYS_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // address[31:0]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // l1_hit, l2_probed, l2_hit, victim_to_l2, dirty_evict, 0
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);
  import sl1c_pkg::*;

  localparam int unsigned L2_LINES = L2_BYTES / 8;
  localparam int unsigned L1_AW    = $clog2(2 * L1_LINES_MAX);
  localparam int unsigned L2_AW    = $clog2(L2_LINES);
  localparam int unsigned L2_OFFB  = $clog2(L2_BYTES);
  localparam int unsigned L2_WB    = $clog2(L2_WAYS);
  localparam int unsigned KMAX     = clog2_floor(L1_LINES_MAX);
  localparam int unsigned WMAX     = clog2_floor(L1_WAYS_MAX);
  localparam int unsigned CLR_N    = (2 * L1_LINES_MAX > L2_LINES) ?
                                     2 * L1_LINES_MAX : L2_LINES;
  localparam int unsigned CLR_W    = $clog2(CLR_N + 1);
  localparam int unsigned WCW      = 5;

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_L1RD   = 10'b0000000100,
    ST_L1CHK  = 10'b0000001000,
    ST_L1VIC  = 10'b0000010000,
    ST_PRRD   = 10'b0000100000,
    ST_PRCHK  = 10'b0001000000,
    ST_INRD   = 10'b0010000000,
    ST_INCHK  = 10'b0100000000,
    ST_INLRU  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [4:0] cfg_l1_q;
  logic [2:0] cfg_blk_q;
  logic [1:0] cfg_ways_q;

  logic [31:0] stamp_q, stamp_d;
  logic [31:0] addr_q;
  logic [1:0]  act_q;
  logic [WCW-1:0] way_q, way_d;
  logic [CLR_W-1:0] clr_q;
  logic        have_q, have_d;
  logic [WCW-1:0] lru_way_q, lru_way_d;
  logic [31:0] lru_stamp_q, lru_stamp_d;
  logic [31:0] lru_tag_q, lru_tag_d;
  logic [1:0]  lru_kind_q, lru_kind_d;
  logic [31:0] vaddr_q, vaddr_d;
  logic [1:0]  vkind_q, vkind_d;
  logic        evict_q, evict_d;
  result_t     res_q, res_d;
  logic        out_v_q, out_v_d;

  // Geometry from the registers.
  logic [2:0] b;
  logic [4:0] l1c, lb, w, l1e;
  always_comb begin
    b   = (cfg_blk_q < 3'd3) ? 3'd3 : ((cfg_blk_q > 3'd6) ? 3'd6 : cfg_blk_q);
    l1c = (cfg_l1_q < 5'd6) ? 5'd6 : ((cfg_l1_q > 5'd16) ? 5'd16 : cfg_l1_q);
    lb  = l1c - {2'd0, b};
    if (lb > 5'(KMAX)) lb = 5'(KMAX);
    w   = {3'd0, cfg_ways_q};
    if (w > lb) w = lb;
    if (w > 5'(WMAX)) w = 5'(WMAX);
    l1e = {2'd0, b} + lb;
  end

  logic [31:0] l1_tag, l1_set, l1_line, l1_vic_line;
  logic        is_i;
  logic [1:0]  kind_in;
  assign is_i    = (act_q == ACT_FETCH);
  assign kind_in = (act_q == ACT_RSVD) ? ACT_READ : act_q;
  assign l1_tag  = addr_q >> l1e;
  assign l1_set  = (addr_q & ((32'd1 << l1e) - 32'd1)) >> ({2'd0, b} + w);
  assign l1_line = ((l1_set << w) + {27'd0, way_q}) & 32'(L1_LINES_MAX - 1);
  assign l1_vic_line = ((l1_set << w) + {27'd0, lru_way_q}) & 32'(L1_LINES_MAX - 1);

  // L2 address for probe or insert.
  logic [31:0] l2_src, l2_tag, l2_set, l2_line, l2_lru_line;
  assign l2_src  = state_q inside {ST_PRRD, ST_PRCHK} ? addr_q : vaddr_q;
  assign l2_tag  = l2_src >> L2_OFFB;
  assign l2_set  = ((l2_src & 32'(L2_BYTES - 1)) >> b) >> L2_WB;
  assign l2_line = ((l2_set << L2_WB) + {27'd0, way_q}) & 32'(L2_LINES - 1);
  assign l2_lru_line = ((l2_set << L2_WB) + {27'd0, lru_way_q}) & 32'(L2_LINES - 1);

  logic [L1_AW-1:0] l1_addr;
  logic [L2_AW-1:0] l2_addr;
  logic l1_we, l2_we;
  line_t l1_wd, l2_wd, l1_rd, l2_rd;
  logic [LINE_W-1:0] l1_rd_raw, l2_rd_raw;
  assign l1_rd = line_t'(l1_rd_raw);
  assign l2_rd = line_t'(l2_rd_raw);

  logic [WCW-1:0] l1_ways_n;
  assign l1_ways_n = WCW'(1) << w;

  always_comb begin
    state_d = state_q;
    stamp_d = stamp_q;
    way_d = way_q;
    have_d = have_q;
    lru_way_d = lru_way_q;
    lru_stamp_d = lru_stamp_q;
    lru_tag_d = lru_tag_q;
    lru_kind_d = lru_kind_q;
    vaddr_d = vaddr_q;
    vkind_d = vkind_q;
    evict_d = evict_q;
    res_d = res_q;
    out_v_d = out_v_q;
    l1_we = 1'b0;
    l2_we = 1'b0;
    l1_wd = '0;
    l2_wd = '0;
    l1_addr = {is_i, l1_line[L1_AW-2:0]};
    l2_addr = l2_line[L2_AW-1:0];
    if (m_axis_tvalid && m_axis_tready) out_v_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        l1_we = (clr_q < CLR_W'(2 * L1_LINES_MAX));
        l2_we = (clr_q < CLR_W'(L2_LINES));
        l1_addr = clr_q[L1_AW-1:0];
        l2_addr = clr_q[L2_AW-1:0];
        if (clr_q == CLR_W'(CLR_N - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          stamp_d = stamp_q + 32'd1;
          way_d = '0;
          have_d = 1'b0;
          evict_d = 1'b0;
          res_d = '0;
          state_d = ST_L1RD;
        end
      end
      ST_L1RD: state_d = ST_L1CHK;
      ST_L1CHK: begin
        if (!l1_rd.valid) begin
          l1_we = 1'b1;
          l1_wd = '{valid: 1'b1, tag: l1_tag, stamp: stamp_q, kind: kind_in};
          res_d.l2_probed = 1'b1;
          way_d = '0;
          state_d = ST_PRRD;
        end else if (l1_rd.tag == l1_tag) begin
          l1_we = 1'b1;
          l1_wd = '{valid: 1'b1, tag: l1_rd.tag, stamp: stamp_q,
                    kind: (act_q == ACT_WRITE) ? KIND_DIRTY : l1_rd.kind};
          res_d.l1_hit = 1'b1;
          out_v_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          if (!have_q || l1_rd.stamp < lru_stamp_q) begin
            have_d = 1'b1;
            lru_way_d = way_q;
            lru_stamp_d = l1_rd.stamp;
            lru_tag_d = l1_rd.tag;
            lru_kind_d = l1_rd.kind;
          end
          if (way_q == l1_ways_n - WCW'(1)) begin
            state_d = ST_L1VIC;
          end else begin
            way_d = way_q + WCW'(1);
            state_d = ST_L1RD;
          end
        end
      end
      ST_L1VIC: begin
        // The LRU line's tag and kind were kept during the scan.
        l1_addr = {is_i, l1_vic_line[L1_AW-2:0]};
        vaddr_d = (lru_tag_q << l1e) + (l1_set << ({2'd0, b} + w))
                  + ({27'd0, lru_way_q} << b);
        vkind_d = lru_kind_q;
        l1_we = 1'b1;
        l1_wd = '{valid: 1'b1, tag: l1_tag, stamp: stamp_q, kind: kind_in};
        evict_d = 1'b1;
        res_d.victim_to_l2 = 1'b1;
        res_d.l2_probed = 1'b1;
        way_d = '0;
        state_d = ST_PRRD;
      end
      ST_PRRD: state_d = ST_PRCHK;
      ST_PRCHK: begin
        if (!l2_rd.valid || l2_rd.tag == l2_tag || way_q == WCW'(L2_WAYS - 1)) begin
          if (l2_rd.valid && l2_rd.tag == l2_tag) begin
            l2_we = 1'b1;
            l2_wd = '0;
            res_d.l2_hit = 1'b1;
          end
          way_d = '0;
          have_d = 1'b0;
          if (evict_q) begin
            state_d = ST_INRD;
          end else begin
            out_v_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          way_d = way_q + WCW'(1);
          state_d = ST_PRRD;
        end
      end
      ST_INRD: state_d = ST_INCHK;
      ST_INCHK: begin
        if (!l2_rd.valid) begin
          l2_we = 1'b1;
          l2_wd = '{valid: 1'b1, tag: l2_tag, stamp: stamp_q, kind: vkind_q};
          out_v_d = 1'b1;
          state_d = ST_IDLE;
        end else if (l2_rd.tag == l2_tag) begin
          l2_we = 1'b1;
          l2_wd = '{valid: 1'b1, tag: l2_tag, stamp: stamp_q,
                    kind: (vkind_q == KIND_DIRTY) ? KIND_DIRTY : l2_rd.kind};
          out_v_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          if (!have_q || l2_rd.stamp < lru_stamp_q) begin
            have_d = 1'b1;
            lru_way_d = way_q;
            lru_stamp_d = l2_rd.stamp;
            lru_kind_d = l2_rd.kind;
          end
          if (way_q == WCW'(L2_WAYS - 1)) begin
            state_d = ST_INLRU;
          end else begin
            way_d = way_q + WCW'(1);
            state_d = ST_INRD;
          end
        end
      end
      ST_INLRU: begin
        // Replace the LRU line; its kind was kept during the scan.
        l2_addr = l2_lru_line[L2_AW-1:0];
        l2_we = 1'b1;
        l2_wd = '{valid: 1'b1, tag: l2_tag, stamp: stamp_q, kind: vkind_q};
        res_d.dirty_evict = (lru_kind_q == KIND_DIRTY);
        out_v_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cfg_l1_q   <= 5'd12;
      cfg_blk_q  <= 3'd3;
      cfg_ways_q <= 2'd1;
      stamp_q    <= '0;
      clr_q      <= '0;
      out_v_q    <= 1'b0;
      have_q     <= 1'b0;
      evict_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      stamp_q <= stamp_d;
      out_v_q <= out_v_d;
      have_q  <= have_d;
      evict_q <= evict_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + CLR_W'(1);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_L1_BYTES:  cfg_l1_q   <= cfg_data_i;
          CFG_BLK_BYTES: cfg_blk_q  <= cfg_data_i[2:0];
          CFG_L1_WAYS:   cfg_ways_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    way_q       <= way_d;
    lru_way_q   <= lru_way_d;
    lru_stamp_q <= lru_stamp_d;
    lru_tag_q   <= lru_tag_d;
    lru_kind_q  <= lru_kind_d;
    vaddr_q     <= vaddr_d;
    vkind_q     <= vkind_d;
    res_q       <= res_d;
    if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready) begin
      addr_q <= s_axis_tdata;
      act_q  <= s_axis_tuser;
    end
  end

  sl1c_ram #(.Width(LINE_W), .Depth(2 * L1_LINES_MAX)) u_l1_ram (
    .clk_i  (clk_i),
    .we_i   (l1_we),
    .addr_i (l1_addr),
    .wdata_i(l1_wd),
    .rdata_o(l1_rd_raw)
  );

  sl1c_ram #(.Width(LINE_W), .Depth(L2_LINES)) u_l2_ram (
    .clk_i  (clk_i),
    .we_i   (l2_we),
    .addr_i (l2_addr),
    .wdata_i(l2_wd),
    .rdata_o(l2_rd_raw)
  );

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_v_q || m_axis_tready);
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'd0, res_q.dirty_evict, res_q.victim_to_l2, res_q.l2_hit,
                          res_q.l2_probed, res_q.l1_hit};

`ifndef SYNTH
  a_hit_no_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res_q.l1_hit && res_q.l2_probed)) else $error("hit and probe");
  a_l2hit_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.l2_hit |-> res_q.l2_probed) else $error("l2 hit w/o probe");
  a_evict_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.dirty_evict |-> res_q.victim_to_l2)
    else $error("dirty eviction w/o victim");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == ST_IDLE) else $error("ready while busy");
`endif
endmodule
